// ===== sv/reply_frame_deframer_checksum_core_assert.svh =====
// Assertion macros used by the checker file.
// Every check samples on the rising clock edge and is off while reset is held.
`ifndef REPLY_FRAME_DEFRAMER_CHECKSUM_CORE_ASSERT_SVH
`define REPLY_FRAME_DEFRAMER_CHECKSUM_CORE_ASSERT_SVH

`define RFDC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deframer check failed");

// Check a condition on every result word that is on offer.
`define RFDC_ASSERT_OUT(label, expr) \
    `RFDC_ASSERT(label, out_valid |-> (expr))

`endif

// ===== sv/rfdc_pkg.sv =====
package rfdc_pkg;

    localparam int RX_BUFFER_SIZE = 256;

    localparam int POS_W = 9;

    localparam logic [7:0]       HDR_BYTE     = 8'h71;
    localparam logic [POS_W-1:0] STATUS_LEN   = POS_W'(203);
    localparam logic [POS_W-1:0] OPTIONAL_LEN = POS_W'(20);
    localparam logic [POS_W-1:0] LEN_OVERHEAD = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(RX_BUFFER_SIZE - 1);
    localparam logic [POS_W-1:0] LEN_LIMIT    = POS_W'(RX_BUFFER_SIZE - 3);

    localparam logic [1:0] KIND_OTHER    = 2'd0;
    localparam logic [1:0] KIND_STATUS   = 2'd1;
    localparam logic [1:0] KIND_OPTIONAL = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [7:0]       length;
        logic [7:0]       sum;
    } rfdc_state_t;

    typedef struct packed {
        logic       in_frame;
        logic [7:0] byte_index;
        logic       frame_done;
        logic       checksum_ok;
        logic [1:0] frame_kind;
    } rfdc_result_t;

endpackage

// ===== sv/rfdc_frame_logic.sv =====
module rfdc_frame_logic
    import rfdc_pkg::*;
(
    input  rfdc_state_t  state,
    input  logic [7:0]   rx_byte,
    output rfdc_state_t  state_next,
    output rfdc_result_t result
);

    logic [POS_W-1:0] at;
    logic [POS_W-1:0] next_pos;
    logic [POS_W-1:0] frame_len;
    logic [7:0]       sum_new;
    logic [7:0]       len_new;
    logic             kept;
    logic             done;

    always_comb
    begin
        // Drop a partial frame once the buffer is full; this byte may start a new one.
        at = (state.position >= POS_LIMIT) ? '0 : state.position;

        sum_new = (at == '0) ? rx_byte : 8'(state.sum + rx_byte);
        len_new = (at == POS_W'(1)) ? rx_byte : state.length;

        next_pos  = at + POS_W'(1);
        kept      = 1'b1;
        frame_len = {1'b0, len_new} + LEN_OVERHEAD;

        if (at == '0 && rx_byte != HDR_BYTE)
        begin
            next_pos = '0;
            kept     = 1'b0;
        end
        if (at == POS_W'(1) && {1'b0, len_new} > LEN_LIMIT)
        begin
            next_pos = '0;
            kept     = 1'b0;
        end

        done = (next_pos >= POS_W'(2)) && (next_pos == frame_len);

        result.in_frame    = kept;
        result.byte_index  = kept ? at[7:0] : 8'd0;
        result.frame_done  = done;
        result.checksum_ok = done && (sum_new == 8'd0);
        result.frame_kind  = KIND_OTHER;
        if (done)
        begin
            if (next_pos == STATUS_LEN)
                result.frame_kind = KIND_STATUS;
            else if (next_pos == OPTIONAL_LEN)
                result.frame_kind = KIND_OPTIONAL;
        end

        state_next.position = done ? '0 : next_pos;
        state_next.length   = len_new;
        state_next.sum      = sum_new;
    end

endmodule

// ===== sv/reply_frame_deframer_checksum_core.sv =====
// An accepted input word is registered in the input stage, its result word in
// the output stage. Throughput: one word per cycle while out_stall is low; the
// frame position, length and 8-bit sum update as the input stage hands it on.
// Reset (rst_n low, asynchronous): both stages empty, frame state cleared to
// position 0, length 0, sum 0.
module reply_frame_deframer_checksum_core
    import rfdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       in_frame,
    output logic [7:0] byte_index,
    output logic       frame_done,
    output logic       checksum_ok,
    output logic [1:0] frame_kind
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    rfdc_result_t out_reg;
    rfdc_state_t  state_reg;
    rfdc_state_t  state_next;
    rfdc_result_t result_next;
    logic         out_ready;
    logic         advance;

    rfdc_frame_logic u_frame_logic (
        .state      (state_reg),
        .rx_byte    (in_byte_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (out_ready)
                out_valid_reg <= in_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Hold payload while its stage is stalled.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_byte_reg <= rx_byte;
        if (advance)
            out_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign in_frame    = out_reg.in_frame;
    assign byte_index  = out_reg.byte_index;
    assign frame_done  = out_reg.frame_done;
    assign checksum_ok = out_reg.checksum_ok;
    assign frame_kind  = out_reg.frame_kind;

endmodule

// ===== sv/rfdc_checker.sv =====
`include "reply_frame_deframer_checksum_core_assert.svh"

module rfdc_checker
    import rfdc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       in_frame,
    input logic [7:0] byte_index,
    input logic       frame_done,
    input logic       checksum_ok,
    input logic [1:0] frame_kind
);

    // The word that completes a frame is always a kept word.
    `RFDC_ASSERT_OUT(a_done_kept, !frame_done || in_frame)
    `RFDC_ASSERT_OUT(a_sum_needs_done, !checksum_ok || frame_done)
    `RFDC_ASSERT_OUT(a_kind_needs_done, frame_kind == KIND_OTHER || frame_done)
    `RFDC_ASSERT_OUT(a_dropped_index_zero, in_frame || byte_index == 8'd0)
    `RFDC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(byte_index)
        && $stable(frame_done) && $stable(checksum_ok) && $stable(frame_kind))

endmodule

bind reply_frame_deframer_checksum_core rfdc_checker u_rfdc_checker (.*);
